### hw/rtl/cst_pkg.sv
// ----------------------------------------------------------------------------
// cst_pkg
// Shared types and constants of the character stream tokenizer: token kind
// codes, the token word, the push bundle and the keyword spelling tables.
// ----------------------------------------------------------------------------
package cst_pkg;

    localparam int POS_BITS_DEF = 16;
    localparam int TQ_DEPTH     = 4;

    localparam logic [4:0] K_LPAREN        = 5'd0;
    localparam logic [4:0] K_RPAREN        = 5'd1;
    localparam logic [4:0] K_COMMA         = 5'd2;
    localparam logic [4:0] K_SEMI          = 5'd3;
    localparam logic [4:0] K_PLUS          = 5'd4;
    localparam logic [4:0] K_MINUS         = 5'd5;
    localparam logic [4:0] K_STAR          = 5'd6;
    localparam logic [4:0] K_SLASH         = 5'd7;
    localparam logic [4:0] K_ASSIGN        = 5'd8;
    localparam logic [4:0] K_EQUAL         = 5'd9;
    localparam logic [4:0] K_NOT           = 5'd10;
    localparam logic [4:0] K_NOT_EQUAL     = 5'd11;
    localparam logic [4:0] K_GREATER       = 5'd12;
    localparam logic [4:0] K_GREATER_EQUAL = 5'd13;
    localparam logic [4:0] K_LESS          = 5'd14;
    localparam logic [4:0] K_LESS_EQUAL    = 5'd15;
    localparam logic [4:0] K_AMP           = 5'd16;
    localparam logic [4:0] K_PIPE          = 5'd17;
    localparam logic [4:0] K_END           = 5'd18;
    localparam logic [4:0] K_IDENT         = 5'd19;
    localparam logic [4:0] K_NUMBER        = 5'd20;
    localparam logic [4:0] K_KW_TRUE       = 5'd21;
    localparam logic [4:0] K_KW_FALSE      = 5'd22;
    localparam logic [4:0] K_KW_PRINT      = 5'd23;
    localparam logic [4:0] K_ERROR         = 5'd24;

    localparam int KW_COUNT = 3;

    typedef struct packed {
        logic [4:0]  kind;
        logic [15:0] start;
        logic [15:0] len;
        logic [15:0] line;
        logic        last;
    } token_t;

    // tokens produced by one byte, in order, cnt of them valid
    typedef struct packed {
        logic [1:0] cnt;
        token_t     tok0;
        token_t     tok1;
    } tok_push_t;

    function automatic token_t mk_tok(logic [4:0] kind, logic [15:0] start,
                                      logic [15:0] len, logic [15:0] line);
        token_t t;
        t.kind  = kind;
        t.start = start;
        t.len   = len;
        t.line  = line;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic logic [2:0] kw_len(logic [1:0] k);
        logic [2:0] r;
        case (k)
            2'd0:    r = 3'd4;
            default: r = 3'd5;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] kw_byte(logic [1:0] k, logic [2:0] i);
        logic [7:0] r;
        r = 8'h00;
        case (k)
            2'd0: begin
                case (i)
                    3'd0:    r = "t";
                    3'd1:    r = "r";
                    3'd2:    r = "u";
                    3'd3:    r = "e";
                    default: r = 8'h00;
                endcase
            end
            2'd1: begin
                case (i)
                    3'd0:    r = "f";
                    3'd1:    r = "a";
                    3'd2:    r = "l";
                    3'd3:    r = "s";
                    3'd4:    r = "e";
                    default: r = 8'h00;
                endcase
            end
            default: begin
                case (i)
                    3'd0:    r = "p";
                    3'd1:    r = "r";
                    3'd2:    r = "i";
                    3'd3:    r = "n";
                    3'd4:    r = "t";
                    default: r = 8'h00;
                endcase
            end
        endcase
        return r;
    endfunction

endpackage

### hw/rtl/cst_scan.sv
// ----------------------------------------------------------------------------
// cst_scan
// Scanner state and the single-pass step logic: classifies one byte, resolves
// the operator lookahead, tracks identifiers, numbers and comments, and
// produces the zero to two tokens that the byte causes.
// ----------------------------------------------------------------------------
module cst_scan #(
    parameter int POS_BITS = cst_pkg::POS_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          char_code,
    input  logic                final_char,
    output cst_pkg::tok_push_t  push
);

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_OP,
        MODE_COMMENT,
        MODE_IDENT,
        MODE_NUMBER
    } mode_t;

    localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

    mode_t               mode_reg, mode_next;
    logic [7:0]          pend_reg, pend_next;
    logic [POS_BITS-1:0] pos_reg, pos_next;
    logic [POS_BITS-1:0] start_reg, start_next;
    logic [POS_BITS-1:0] line_reg, line_next;
    logic [POS_BITS-1:0] len_reg, len_next;
    logic [2:0]          hits_reg, hits_next;

    function automatic logic [POS_BITS-1:0] sat_inc(logic [POS_BITS-1:0] v);
        return (v == POS_MAX) ? v : v + 1'b1;
    endfunction

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    // drop every keyword whose byte at idx differs or that is already over
    function automatic logic [2:0] kw_check(logic [2:0] hits, logic [7:0] c,
                                            logic [POS_BITS-1:0] idx);
        logic [2:0] r;
        r = hits;
        for (int k = 0; k < cst_pkg::KW_COUNT; k++) begin
            if (idx >= POS_BITS'(cst_pkg::kw_len(2'(k))) ||
                cst_pkg::kw_byte(2'(k), idx[2:0]) != c)
            begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    function automatic logic [4:0] single_kind(logic [7:0] op);
        logic [4:0] r;
        case (op)
            "/":     r = cst_pkg::K_SLASH;
            "!":     r = cst_pkg::K_NOT;
            ">":     r = cst_pkg::K_GREATER;
            "<":     r = cst_pkg::K_LESS;
            default: r = cst_pkg::K_ERROR;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] ident_kind(logic [2:0] hits,
                                              logic [POS_BITS-1:0] len);
        logic [4:0] r;
        r = cst_pkg::K_IDENT;
        for (int k = cst_pkg::KW_COUNT - 1; k >= 0; k--) begin
            if (hits[k] && len == POS_BITS'(cst_pkg::kw_len(2'(k))))
                r = cst_pkg::K_KW_TRUE + 5'(k);
        end
        return r;
    endfunction

    function automatic logic [4:0] pair_kind(logic [7:0] op);
        logic [4:0] r;
        case (op)
            ":":     r = cst_pkg::K_ASSIGN;
            "!":     r = cst_pkg::K_NOT_EQUAL;
            ">":     r = cst_pkg::K_GREATER_EQUAL;
            default: r = cst_pkg::K_LESS_EQUAL;
        endcase
        return r;
    endfunction

    cst_pkg::token_t a_tok, b_tok, c_tok, s0_tok, s1_tok;
    logic            a_vld, b_vld, c_vld, used;
    logic [15:0]     line16, pos16;
    logic [1:0]      n_tok;

    always_comb begin
        mode_next  = mode_reg;
        pend_next  = pend_reg;
        start_next = start_reg;
        line_next  = line_reg;
        len_next   = len_reg;
        hits_next  = hits_reg;
        pos_next   = sat_inc(pos_reg);
        line16     = 16'(line_reg);
        pos16      = 16'(pos_reg);
        a_vld      = 1'b0;
        b_vld      = 1'b0;
        c_vld      = 1'b0;
        a_tok      = cst_pkg::mk_tok(cst_pkg::K_ERROR, 16'(start_reg), 16'd1, line16);
        b_tok      = cst_pkg::mk_tok(cst_pkg::K_ERROR, pos16, 16'd1, line16);
        c_tok      = a_tok;
        used       = 1'b0;

        // pending token against this byte
        unique case (mode_reg)
            MODE_OP: begin
                if (char_code == "=" && pend_reg != "/") begin
                    a_vld     = 1'b1;
                    a_tok     = cst_pkg::mk_tok(pair_kind(pend_reg), 16'(start_reg),
                                                16'd2, line16);
                    mode_next = MODE_IDLE;
                    used      = 1'b1;
                end else if (char_code == "/" && pend_reg == "/") begin
                    mode_next = MODE_COMMENT;
                    used      = 1'b1;
                end else begin
                    a_vld     = 1'b1;
                    a_tok     = cst_pkg::mk_tok(single_kind(pend_reg), 16'(start_reg),
                                                16'd1, line16);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_COMMENT: begin
                // newline or zero byte closes the comment and is scanned fresh
                if (char_code != "\n" && char_code != 8'h00)
                    used = 1'b1;
                else
                    mode_next = MODE_IDLE;
            end
            MODE_IDENT: begin
                if (is_alpha(char_code) || is_digit(char_code)) begin
                    hits_next = kw_check(hits_reg, char_code, len_reg);
                    len_next  = sat_inc(len_reg);
                    used      = 1'b1;
                end else begin
                    a_vld     = 1'b1;
                    a_tok     = cst_pkg::mk_tok(ident_kind(hits_reg, len_reg),
                                                16'(start_reg), 16'(len_reg), line16);
                    mode_next = MODE_IDLE;
                end
            end
            MODE_NUMBER: begin
                if (is_digit(char_code)) begin
                    len_next = sat_inc(len_reg);
                    used     = 1'b1;
                end else begin
                    a_vld     = 1'b1;
                    a_tok     = cst_pkg::mk_tok(cst_pkg::K_NUMBER, 16'(start_reg),
                                                16'(len_reg), line16);
                    mode_next = MODE_IDLE;
                end
            end
            default: mode_next = MODE_IDLE;
        endcase

        // fresh scan of the byte
        if (!used) begin
            case (char_code) inside
                "(": begin b_vld = 1'b1; b_tok.kind = cst_pkg::K_LPAREN; end
                ")": begin b_vld = 1'b1; b_tok.kind = cst_pkg::K_RPAREN; end
                ",": begin b_vld = 1'b1; b_tok.kind = cst_pkg::K_COMMA;  end
                ";": begin b_vld = 1'b1; b_tok.kind = cst_pkg::K_SEMI;   end
                "+": begin b_vld = 1'b1; b_tok.kind = cst_pkg::K_PLUS;   end
                "-": begin b_vld = 1'b1; b_tok.kind = cst_pkg::K_MINUS;  end
                "*": begin b_vld = 1'b1; b_tok.kind = cst_pkg::K_STAR;   end
                "=": begin b_vld = 1'b1; b_tok.kind = cst_pkg::K_EQUAL;  end
                "&": begin b_vld = 1'b1; b_tok.kind = cst_pkg::K_AMP;    end
                "|": begin b_vld = 1'b1; b_tok.kind = cst_pkg::K_PIPE;   end
                8'h00: begin b_vld = 1'b1; b_tok.kind = cst_pkg::K_END;  end
                "/", ":", "!", ">", "<": begin
                    mode_next  = MODE_OP;
                    pend_next  = char_code;
                    start_next = pos_reg;
                end
                " ", "\t": begin
                end
                "\n": line_next = sat_inc(line_reg);
                default: begin
                    if (is_alpha(char_code)) begin
                        mode_next  = MODE_IDENT;
                        start_next = pos_reg;
                        hits_next  = kw_check(3'b111, char_code, '0);
                        len_next   = POS_BITS'(1);
                    end else if (is_digit(char_code)) begin
                        mode_next  = MODE_NUMBER;
                        start_next = pos_reg;
                        len_next   = POS_BITS'(1);
                    end else begin
                        b_vld = 1'b1;
                    end
                end
            endcase
        end

        // final byte flushes what is still pending
        if (final_char) begin
            case (mode_next)
                MODE_OP: begin
                    c_vld = 1'b1;
                    c_tok = cst_pkg::mk_tok(single_kind(pend_next), 16'(start_next),
                                            16'd1, line16);
                end
                MODE_IDENT: begin
                    c_vld = 1'b1;
                    c_tok = cst_pkg::mk_tok(ident_kind(hits_next, len_next),
                                            16'(start_next), 16'(len_next), line16);
                end
                MODE_NUMBER: begin
                    c_vld = 1'b1;
                    c_tok = cst_pkg::mk_tok(cst_pkg::K_NUMBER, 16'(start_next),
                                            16'(len_next), line16);
                end
                default: c_vld = 1'b0;
            endcase
            mode_next = MODE_IDLE;
            pend_next = 8'h00;
        end

        // pack in order; at most two of the three exist
        if (a_vld) begin
            s0_tok = a_tok;
            s1_tok = b_vld ? b_tok : c_tok;
        end else if (b_vld) begin
            s0_tok = b_tok;
            s1_tok = c_tok;
        end else begin
            s0_tok = c_tok;
            s1_tok = c_tok;
        end
        n_tok       = 2'(a_vld) + 2'(b_vld) + 2'(c_vld);
        s0_tok.last = (n_tok == 2'd1);
        s1_tok.last = 1'b1;

        push.cnt  = step ? n_tok : 2'd0;
        push.tok0 = s0_tok;
        push.tok1 = s1_tok;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            pend_reg  <= 8'h00;
            pos_reg   <= '0;
            start_reg <= '0;
            line_reg  <= POS_BITS'(1);
            len_reg   <= '0;
            hits_reg  <= 3'b111;
        end else if (step) begin
            mode_reg  <= mode_next;
            pend_reg  <= pend_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            line_reg  <= line_next;
            len_reg   <= len_next;
            hits_reg  <= hits_next;
        end
    end

`ifndef ASSERT_OFF
    a_final_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && final_char |=> mode_reg == MODE_IDLE)
        else $error("scanner not idle after final byte");

    a_line_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        line_reg != '0)
        else $error("line count reached zero");

    a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd2 |-> push.tok1.last && !push.tok0.last)
        else $error("last marker misplaced on token pair");
`endif

endmodule

### hw/rtl/cst_tokq.sv
// ----------------------------------------------------------------------------
// cst_tokq
// Result queue: takes up to two tokens per byte and hands them out one word
// per cycle while out_stall is low; reports room while two more tokens fit.
// ----------------------------------------------------------------------------
module cst_tokq (
    input  logic               clk,
    input  logic               rst_n,
    input  cst_pkg::tok_push_t push,
    output logic               room,
    output logic               out_valid,
    input  logic               out_stall,
    output cst_pkg::token_t    head
);

    localparam int PW = $clog2(cst_pkg::TQ_DEPTH);
    localparam int CW = $clog2(cst_pkg::TQ_DEPTH + 1);

    cst_pkg::token_t mem_reg [cst_pkg::TQ_DEPTH];
    logic [PW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid && !out_stall;
    assign room      = (cnt_reg <= CW'(cst_pkg::TQ_DEPTH - 2));
    assign head      = mem_reg[rd_reg];

    always_comb begin
        wr_next  = wr_reg + PW'(push.cnt);
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk) begin
        if (push.cnt != 2'd0)
            mem_reg[wr_reg] <= push.tok0;
        if (push.cnt == 2'd2)
            mem_reg[wr_reg + 1'b1] <= push.tok1;
    end

`ifndef ASSERT_OFF
    a_push_fits: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt != 2'd0 |-> cnt_reg <= CW'(cst_pkg::TQ_DEPTH - 2))
        else $error("token push without room");

    a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
        push.cnt == 2'd0 && pop |=> cnt_reg == $past(cnt_reg) - 1'b1)
        else $error("queue count out of step with pops");
`endif

endmodule

### hw/rtl/char_stream_tokenizer.sv
// ----------------------------------------------------------------------------
// char_stream_tokenizer
// Byte-serial lexer: operators with one byte of lookahead, line comments,
// identifiers with keyword match, numbers, END and ERROR tokens.
//
//   channel  valid      stall      words
//   in       in_valid   in_stall   char_code, final_char
//   out      out_valid  out_stall  token_kind, start_pos, token_len,
//                                  line_num, run_last
//
// one byte per cycle sustained while in_stall is low; a byte is scanned from
// the input register; its tokens leave the result queue one token word
// per cycle while out_stall is low; a byte with two tokens takes two entries
// in_stall rises only while a byte waits in the input register and the
// result queue has no space left for two tokens
// reset clears scanner state, positions to 0, line count to 1
// ----------------------------------------------------------------------------
module char_stream_tokenizer #(
    parameter int POS_BITS = cst_pkg::POS_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  char_code,
    input  logic        final_char,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [4:0]  token_kind,
    output logic [15:0] start_pos,
    output logic [15:0] token_len,
    output logic [15:0] line_num,
    output logic        run_last
);

    logic               full_reg, full_next;
    logic [7:0]         char_reg;
    logic               fin_reg;
    logic               room, step, take;
    cst_pkg::tok_push_t push;
    cst_pkg::token_t    head;

    assign step     = full_reg && room;
    assign in_stall = full_reg && !room;
    assign take     = in_valid && !in_stall;

    always_comb begin
        full_next = full_reg;
        if (take)
            full_next = 1'b1;
        else if (step)
            full_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            full_reg <= 1'b0;
        else
            full_reg <= full_next;
    end

    always_ff @(posedge clk) begin
        if (take) begin
            char_reg <= char_code;
            fin_reg  <= final_char;
        end
    end

    cst_scan #(
        .POS_BITS (POS_BITS)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .char_code  (char_reg),
        .final_char (fin_reg),
        .push       (push)
    );

    cst_tokq u_tokq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .head      (head)
    );

    assign token_kind = head.kind;
    assign start_pos  = head.start;
    assign token_len  = head.len;
    assign line_num   = head.line;
    assign run_last   = head.last;

`ifndef ASSERT_OFF
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        full_reg && !step |=> full_reg && $stable(char_reg))
        else $error("held input word lost");
`endif

endmodule
